// ===== design/lsf_pkg.sv =====
package lsf_pkg;

  // Default store depth and the widths that follow from it.
  localparam int unsigned MAX_POINTS_DEFAULT = 256;
  localparam int unsigned COUNT_W_DEFAULT    = $clog2(MAX_POINTS_DEFAULT + 1);
  localparam int unsigned ACC_W_DEFAULT      = 48 + COUNT_W_DEFAULT;
  localparam int unsigned QUO_W_DEFAULT      = ACC_W_DEFAULT + 16;

  // Square root unit works on a 64-bit radicand, two bits per step.
  localparam int unsigned SQRT_W     = 64;
  localparam int unsigned SQRT_STEPS = SQRT_W / 2;

  // Q16.16 constants and saturation limits.
  localparam logic signed [63:0] HALF_Q16  = 64'sd32768;
  localparam logic signed [63:0] SAT_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN   = 64'shFFFF_FFFF_8000_0000;
  localparam logic [31:0]        SLOPE_POS_CAP = 32'h7FFF_FFFF;
  localparam logic [31:0]        SLOPE_NEG_CAP = 32'h8000_0000;
  localparam logic [46:0]        VAR_CAP       = 47'h7FFF_FFFF_FFFF;
  localparam logic [31:0]        STD_ERR_CAP   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_FIT     = 2'd1,
    MODE_PREDICT = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_ZERO_SPR = 2'd2,
    STATUS_TOO_FEW  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X      = 2'd0,
    CFG_ORIGIN_Y      = 2'd1,
    CFG_FIT_INTERCEPT = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PREDICT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_MX_GO,
    ST_MX_WAIT,
    ST_MY_GO,
    ST_MY_WAIT,
    ST_DEV_RD,
    ST_DEV_SUB,
    ST_DEV_MUL_XY,
    ST_DEV_MUL_XX,
    ST_DEV_ACC,
    ST_CHECK,
    ST_SLOPE_GO,
    ST_SLOPE_WAIT,
    ST_ICPT_MUL,
    ST_ICPT,
    ST_RES_RD,
    ST_RES_MUL,
    ST_RES_SUB,
    ST_RES_SQ,
    ST_RES_ACC,
    ST_RSS_GO,
    ST_RSS_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } request_t;

  typedef struct packed {
    status_e            status;
    logic [8:0]         point_count;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [30:0]        slope_std_error;
    logic signed [31:0] predicted;
  } result_t;

  // One stored point, as offsets from the origin.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/lsf_store.sv =====
module lsf_store #(
  parameter int unsigned DEPTH = lsf_pkg::MAX_POINTS_DEFAULT,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  lsf_pkg::point_t  wdata,
  input  logic [IW-1:0]    raddr,
  output lsf_pkg::point_t  rdata
);
  import lsf_pkg::*;

  point_t mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lsf_div.sv =====
module lsf_div #(
  parameter int unsigned DW = lsf_pkg::QUO_W_DEFAULT,
  parameter int unsigned VW = lsf_pkg::ACC_W_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import lsf_pkg::*;

  localparam int unsigned CTW = $clog2(DW);

  logic [VW-1:0]  rem;
  logic [VW-1:0]  dvs;
  logic [DW-1:0]  quo;
  logic [CTW-1:0] ctr;
  logic           busy;
  logic [VW:0]    rem_sh;
  logic [VW:0]    diff;
  logic           fits;

  // One restoring step: shift in the next dividend bit, try a subtract.
  always_comb begin
    rem_sh = {rem, quo[DW-1]};
    diff   = rem_sh - {1'b0, dvs};
    fits   = !diff[VW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ctr == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Dividend bits leave the top of quo as quotient bits enter the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
      ctr <= CTW'(DW - 1);
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], fits};
      ctr <= ctr - CTW'(1);
    end
  end

  assign quotient = quo;

endmodule

// ===== design/lsf_sqrt.sv =====
module lsf_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lsf_pkg::SQRT_W-1:0] radicand,
  output logic                      done,
  output logic [31:0]               root
);
  import lsf_pkg::*;

  localparam int unsigned CTW = $clog2(SQRT_STEPS);

  logic [SQRT_W-1:0] val;
  logic [SQRT_W-1:0] res;
  logic [SQRT_W-1:0] one;
  logic [SQRT_W-1:0] trial;
  logic [CTW-1:0]    ctr;
  logic              busy;

  assign trial = res + one;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && ctr == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Digit-by-digit square root, one result bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      val <= radicand;
      res <= '0;
      one <= SQRT_W'(1) << (SQRT_W - 2);
      ctr <= CTW'(SQRT_STEPS - 1);
    end else if (busy) begin
      if (val >= trial) begin
        val <= val - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
      ctr <= ctr - CTW'(1);
    end
  end

  assign root = res[31:0];

endmodule

// ===== design/least_squares_line_fit.sv =====
// Channel   Direction  Handshake              Payload
// request   in         request_valid/stall    request_t (mode, point_x, point_y)
// result    out        result_valid/stall     result_t (status ... predicted)
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Add and clear go from dispatch straight to finish, predict via one more
// state. A fit reads the stored points in up to three passes (sums for the
// means in intercept mode only, deviations, residuals) through the single
// read port of the point store, then makes up to five runs of the shared
// divider and one of the square root unit. Reset is synchronous and empties the
// store; a finished result waits in the output register while the next request
// is accepted, and the block holds the following result until it is taken.
module least_squares_line_fit #(
  parameter int unsigned MAX_POINTS = lsf_pkg::MAX_POINTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  lsf_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output lsf_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import lsf_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned AW = 48 + CW;
  localparam int unsigned DW = AW + 16;

  state_e state, state_next;

  request_t           req;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic               fit_intercept;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic signed [31:0] slope_reg;
  logic signed [31:0] intercept_reg;
  logic [30:0]        std_error_reg;
  logic signed [31:0] predicted;
  status_e            status;
  logic signed [SW-1:0] sumx;
  logic signed [SW-1:0] sumy;
  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [AW-1:0] sxy;
  logic signed [AW-1:0] sxx;
  logic [AW-1:0]      rss;
  logic [46:0]        var_q;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [AW-1:0]      div_divisor;
  logic               div_done;
  logic [DW-1:0]      div_quo;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;

  logic               store_we;
  point_t             store_wdata;
  point_t             store_rdata;

  logic               accept;
  logic               out_free;
  logic               idx_last;
  logic               store_full;
  logic signed [63:0] prod_q;
  logic signed [SW-1:0] sumx_mag;
  logic signed [SW-1:0] sumy_mag;
  logic signed [AW-1:0] sxy_mag;
  logic [32:0]        mean_mag;
  logic [31:0]        slope_cap;
  logic [31:0]        slope_mag;

  assign accept        = request_valid && !request_stall;
  assign request_stall = (state != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !result_valid || !result_stall;
  assign idx_last      = ((idx + CW'(1)) == count);
  assign store_full    = (count >= CW'(MAX_POINTS));
  assign prod_q        = prod >>> 16;

  // Magnitudes and saturated quotients around the shared divider.
  always_comb begin
    sumx_mag  = sumx[SW-1] ? -sumx : sumx;
    sumy_mag  = sumy[SW-1] ? -sumy : sumy;
    sxy_mag   = sxy[AW-1] ? -sxy : sxy;
    mean_mag  = div_quo[32:0];
    slope_cap = sxy[AW-1] ? SLOPE_NEG_CAP : SLOPE_POS_CAP;
    slope_mag = (div_quo > DW'(slope_cap)) ? slope_cap : div_quo[31:0];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      fit_intercept <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ORIGIN_X:      origin_x <= cfg_data;
        CFG_ORIGIN_Y:      origin_y <= cfg_data;
        CFG_FIT_INTERCEPT: fit_intercept <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (req.mode)
          MODE_PREDICT: state_next = ST_PREDICT;
          MODE_FIT: begin
            if (count == '0) begin
              state_next = ST_FINISH;
            end else if (fit_intercept) begin
              state_next = ST_SUM_RD;
            end else begin
              state_next = ST_DEV_RD;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_PREDICT:    state_next = ST_FINISH;
      ST_SUM_RD:     state_next = ST_SUM_ACC;
      ST_SUM_ACC:    state_next = idx_last ? ST_MX_GO : ST_SUM_RD;
      ST_MX_GO:      state_next = ST_MX_WAIT;
      ST_MX_WAIT:    if (div_done) state_next = ST_MY_GO;
      ST_MY_GO:      state_next = ST_MY_WAIT;
      ST_MY_WAIT:    if (div_done) state_next = ST_DEV_RD;
      ST_DEV_RD:     state_next = ST_DEV_SUB;
      ST_DEV_SUB:    state_next = ST_DEV_MUL_XY;
      ST_DEV_MUL_XY: state_next = ST_DEV_MUL_XX;
      ST_DEV_MUL_XX: state_next = ST_DEV_ACC;
      ST_DEV_ACC:    state_next = idx_last ? ST_CHECK : ST_DEV_RD;
      ST_CHECK:      state_next = (sxx <= 0) ? ST_FINISH : ST_SLOPE_GO;
      ST_SLOPE_GO:   state_next = ST_SLOPE_WAIT;
      ST_SLOPE_WAIT: if (div_done) state_next = ST_ICPT_MUL;
      ST_ICPT_MUL:   state_next = ST_ICPT;
      ST_ICPT:       state_next = (count < CW'(3)) ? ST_FINISH : ST_RES_RD;
      ST_RES_RD:     state_next = ST_RES_MUL;
      ST_RES_MUL:    state_next = ST_RES_SUB;
      ST_RES_SUB:    state_next = ST_RES_SQ;
      ST_RES_SQ:     state_next = ST_RES_ACC;
      ST_RES_ACC:    state_next = idx_last ? ST_RSS_GO : ST_RES_RD;
      ST_RSS_GO:     state_next = ST_RSS_WAIT;
      ST_RSS_WAIT:   if (div_done) state_next = ST_VAR_GO;
      ST_VAR_GO:     state_next = ST_VAR_WAIT;
      ST_VAR_WAIT:   if (div_done) state_next = ST_SQRT_GO;
      ST_SQRT_GO:    state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT:  if (sqrt_done) state_next = ST_FINISH;
      ST_FINISH:     if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Operand selection for the multiplier, divider, square root and store.
  always_comb begin
    mul_a        = dx;
    mul_b        = dx;
    div_start    = 1'b0;
    div_dividend = DW'($unsigned(sumx_mag));
    div_divisor  = AW'(count);
    sqrt_start   = 1'b0;
    store_we     = 1'b0;
    store_wdata.x = sat32(64'(req.point_x) - 64'(origin_x));
    store_wdata.y = sat32(64'(req.point_y) - 64'(origin_y));
    case (state)
      ST_DISPATCH: begin
        mul_a    = store_wdata.x;
        mul_b    = slope_reg;
        store_we = (req.mode == MODE_ADD) && !store_full;
      end
      ST_MX_GO:      div_start = 1'b1;
      ST_MY_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'($unsigned(sumy_mag));
      end
      ST_DEV_MUL_XY: mul_b = dy;
      ST_SLOPE_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'($unsigned(sxy_mag)) << 16;
        div_divisor  = $unsigned(sxx);
      end
      ST_ICPT_MUL: begin
        mul_a = slope_reg;
        mul_b = mx;
      end
      ST_RES_MUL: begin
        mul_a = store_rdata.x;
        mul_b = slope_reg;
      end
      ST_RSS_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(rss);
        div_divisor  = AW'(count - CW'(2));
      end
      ST_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(rss) << 16;
        div_divisor  = $unsigned(sxx);
      end
      ST_SQRT_GO: sqrt_start = 1'b1;
      default: ;
    endcase
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Sequencer control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      slope_reg     <= '0;
      intercept_reg <= '0;
      std_error_reg <= '0;
      result_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_DISPATCH: begin
          case (req.mode)
            MODE_ADD:   if (!store_full) count <= count + CW'(1);
            MODE_CLEAR: count <= '0;
            MODE_FIT: begin
              if (count == '0) begin
                slope_reg     <= '0;
                intercept_reg <= '0;
                std_error_reg <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_CHECK: begin
          if (sxx <= 0) begin
            slope_reg     <= '0;
            intercept_reg <= my;
            std_error_reg <= '0;
          end
        end
        ST_SLOPE_WAIT: begin
          if (div_done) begin
            slope_reg <= $signed(sxy[AW-1] ? (32'd0 - slope_mag) : slope_mag);
          end
        end
        ST_ICPT: begin
          intercept_reg <= sat32(64'(my) - prod_q);
          if (count < CW'(3)) std_error_reg <= '0;
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            std_error_reg <= (sqrt_root > STD_ERR_CAP) ? STD_ERR_CAP[30:0]
                                                       : sqrt_root[30:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (accept) req <= request;
      ST_DISPATCH: begin
        predicted <= '0;
        idx       <= '0;
        sumx      <= '0;
        sumy      <= '0;
        mx        <= '0;
        my        <= '0;
        sxy       <= '0;
        sxx       <= '0;
        case (req.mode)
          MODE_ADD:     status <= store_full ? STATUS_FULL : STATUS_OK;
          MODE_FIT:     status <= (count == '0) ? STATUS_TOO_FEW : STATUS_OK;
          default:      status <= STATUS_OK;
        endcase
      end
      ST_PREDICT: predicted <= sat32(64'(origin_y) + prod_q + HALF_Q16);
      ST_SUM_ACC: begin
        sumx <= sumx + SW'(store_rdata.x);
        sumy <= sumy + SW'(store_rdata.y);
        idx  <= idx_last ? '0 : idx + CW'(1);
      end
      ST_MX_WAIT: begin
        if (div_done) mx <= 32'(sumx[SW-1] ? (33'd0 - mean_mag) : mean_mag);
      end
      ST_MY_WAIT: begin
        if (div_done) my <= 32'(sumy[SW-1] ? (33'd0 - mean_mag) : mean_mag);
      end
      ST_DEV_SUB: begin
        dx <= sat32(64'(store_rdata.x) - 64'(mx));
        dy <= sat32(64'(store_rdata.y) - 64'(my));
      end
      ST_DEV_MUL_XX: sxy <= sxy + AW'(prod_q);
      ST_DEV_ACC: begin
        sxx <= sxx + AW'(prod_q);
        idx <= idx_last ? '0 : idx + CW'(1);
      end
      ST_CHECK: if (sxx <= 0) status <= STATUS_ZERO_SPR;
      ST_ICPT: begin
        rss <= '0;
        if (count < CW'(3)) status <= STATUS_TOO_FEW;
      end
      ST_RES_SUB: dx <= sat32(64'(store_rdata.y) - (64'(intercept_reg) + prod_q));
      ST_RES_ACC: begin
        rss <= rss + AW'($unsigned(prod_q));
        idx <= idx_last ? '0 : idx + CW'(1);
      end
      ST_RSS_WAIT: if (div_done) rss <= div_quo[AW-1:0];
      ST_VAR_WAIT: begin
        if (div_done) var_q <= (div_quo > DW'(VAR_CAP)) ? VAR_CAP : div_quo[46:0];
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      result.status          <= status;
      result.point_count     <= 9'(count);
      result.slope           <= slope_reg;
      result.intercept       <= intercept_reg;
      result.slope_std_error <= std_error_reg;
      result.predicted       <= predicted;
    end
  end

  lsf_store #(
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IW-1:0]),
    .wdata (store_wdata),
    .raddr (idx[IW-1:0]),
    .rdata (store_rdata)
  );

  lsf_div #(
    .DW (DW),
    .VW (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  lsf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (SQRT_W'(var_q) << 16),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

endmodule

// ===== bench/tb_least_squares_line_fit.sv =====
`timescale 1ns / 1ps

module tb_least_squares_line_fit;
  import lsf_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int RANDOM_ITEMS = 1500;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic request_valid = 1'b0;
  logic request_stall;
  request_t request = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  least_squares_line_fit u_top (
    .clk(clk), .rst(rst),
    .request_valid(request_valid), .request_stall(request_stall), .request(request),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Fit state mirrored from the block's behavior.
  longint pts_x[STORE_DEPTH];
  longint pts_y[STORE_DEPTH];
  int held;
  longint fit_slope, fit_icpt, fit_err;
  longint org_x, org_y;
  bit use_means;

  request_t pending_requests[$];
  result_t expected_results[$];
  int errors = 0;
  longint cycle = 0;
  bit hold_results = 1'b0;
  bit pause_requests = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift is a floor on signed values.
  function automatic longint q16_floor(longint v);
    return v >>> 16;
  endfunction

  function automatic longint unsigned q16_quotient(longint unsigned num,
      longint unsigned den, longint unsigned cap);
    longint unsigned q, r, acc;
    q = num / den;
    r = num % den;
    if (q > (cap >> 16)) return cap;
    acc = q;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      acc = acc << 1;
      if (r >= den) begin
        r = r - den;
        acc = acc | 64'd1;
      end
    end
    return (acc > cap) ? cap : acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic status_e fit_line();
    longint mx, my, sxy, sxx, sl, ic, rss, sumx, sumy, dx, dy, fitted, res;
    longint unsigned mag, variance, sd;
    mx = 0; my = 0; sxy = 0; sxx = 0; rss = 0;
    if (held == 0) begin
      fit_slope = 0; fit_icpt = 0; fit_err = 0;
      return STATUS_TOO_FEW;
    end
    if (use_means) begin
      sumx = 0; sumy = 0;
      for (int i = 0; i < held; i++) begin
        sumx += pts_x[i];
        sumy += pts_y[i];
      end
      mx = sumx / held;
      my = sumy / held;
    end
    for (int i = 0; i < held; i++) begin
      dx = clamp32(pts_x[i] - mx);
      dy = clamp32(pts_y[i] - my);
      sxy += q16_floor(dx * dy);
      sxx += q16_floor(dx * dx);
    end
    if (sxx <= 0) begin
      fit_slope = 0; fit_icpt = clamp32(my); fit_err = 0;
      return STATUS_ZERO_SPR;
    end
    if (sxy < 0) begin
      mag = q16_quotient(-sxy, sxx, 64'd1 << 31);
      sl = -longint'(mag);
    end else begin
      mag = q16_quotient(sxy, sxx, 64'h7FFF_FFFF);
      sl = mag;
    end
    ic = clamp32(my - q16_floor(sl * mx));
    fit_slope = sl;
    fit_icpt = ic;
    if (held < 3) begin
      fit_err = 0;
      return STATUS_TOO_FEW;
    end
    for (int i = 0; i < held; i++) begin
      fitted = ic + q16_floor(pts_x[i] * sl);
      res = clamp32(pts_y[i] - fitted);
      rss += q16_floor(res * res);
    end
    variance = q16_quotient(rss / (held - 2), sxx, (64'd1 << 47) - 1);
    sd = int_sqrt(variance << 16);
    if (sd > 64'h7FFF_FFFF) sd = 64'h7FFF_FFFF;
    fit_err = sd;
    return STATUS_OK;
  endfunction

  // Works out the result of one request and updates the mirrored state.
  function automatic result_t predict_result(request_t rq);
    result_t r;
    longint off;
    r = '0;
    r.status = STATUS_OK;
    case (rq.mode)
      MODE_ADD: begin
        if (held >= STORE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pts_x[held] = clamp32(longint'(rq.point_x) - org_x);
          pts_y[held] = clamp32(longint'(rq.point_y) - org_y);
          held++;
        end
      end
      MODE_FIT: r.status = fit_line();
      MODE_PREDICT: begin
        off = clamp32(longint'(rq.point_x) - org_x);
        r.predicted = clamp32(org_y + q16_floor(off * fit_slope) + 32768);
      end
      default: held = 0;
    endcase
    r.point_count = 9'(held);
    r.slope = fit_slope[31:0];
    r.intercept = fit_icpt[31:0];
    r.slope_std_error = fit_err[30:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("field %s: got %0d, expected %0d at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else if (request_valid && request_stall) begin
      // Hold the offered request.
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      request_valid <= 1'b0;
    end else if (!pause_requests && pending_requests.size() > 0) begin
      request <= pending_requests[0];
      expected_results.push_back(predict_result(pending_requests[0]));
      void'(pending_requests.pop_front());
      request_valid <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      request_valid <= 1'b0;
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    result_t want;
    cycle <= cycle + 1;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (result.status != want.status)
          report_mismatch("status", result.status, want.status);
        if (result.point_count != want.point_count)
          report_mismatch("point_count", result.point_count, want.point_count);
        if (result.slope != want.slope)
          report_mismatch("slope", result.slope, want.slope);
        if (result.intercept != want.intercept)
          report_mismatch("intercept", result.intercept, want.intercept);
        if (result.slope_std_error != want.slope_std_error)
          report_mismatch("slope_std_error", result.slope_std_error,
                          want.slope_std_error);
        if (result.predicted != want.predicted)
          report_mismatch("predicted", result.predicted, want.predicted);
      end
    end
    if (hold_results) begin
      result_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      result_stall <= 1'b1;
    end else begin
      recv_gap <= pick_gap();
      result_stall <= 1'b0;
    end
    if (cycle > CYCLE_LIMIT) begin
      $display("least_squares_line_fit: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t make_request(mode_e m, logic [31:0] x, logic [31:0] y);
    request_t rq;
    rq.mode = m;
    rq.point_x = x;
    rq.point_y = y;
    return rq;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_results.size() > 0 || request_valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    // Mirror the write once it has been taken.
    case (idx)
      CFG_ORIGIN_X: org_x = longint'(signed'(value));
      CFG_ORIGIN_Y: org_y = longint'(signed'(value));
      CFG_FIT_INTERCEPT: use_means = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random point with a scale chosen so fits land in useful ranges.
  function automatic logic [31:0] scaled_value();
    int sh;
    sh = $urandom_range(8, 31);
    return signed'($urandom) >>> (32 - sh);
  endfunction

  // Queue a well-formed session: clear, points mostly near a line, fit, predicts.
  task automatic queue_session(int npts);
    int sl;
    logic [31:0] x, y;
    pending_requests.push_back(make_request(MODE_CLEAR, $urandom, $urandom));
    sl = $urandom_range(0, 1) ? (signed'($urandom) >>> 12) : 0;
    for (int i = 0; i < npts; i++) begin
      x = scaled_value();
      y = (($urandom_range(0, 3) == 0) ? any_value()
          : (signed'(x) >>> 4) * (sl >>> 12) + (signed'($urandom) >>> 14));
      pending_requests.push_back(make_request(MODE_ADD, x, y));
    end
    pending_requests.push_back(make_request(MODE_FIT, $urandom, $urandom));
    repeat ($urandom_range(1, 3))
      pending_requests.push_back(make_request(MODE_PREDICT, any_value(), $urandom));
  endtask

  initial begin
    int queued, n;
    org_x = 0; org_y = 0; use_means = 1'b1;
    held = 0; fit_slope = 0; fit_icpt = 0; fit_err = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty fit, zero spread, three points, extremes, predict, clear.
    pending_requests.push_back(make_request(MODE_FIT, 32'h0, 32'h0));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0001_0000, 32'h0002_0000));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0001_0000, 32'h0005_0000));
    pending_requests.push_back(make_request(MODE_FIT, 32'h0, 32'h0));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0003_0000, 32'h0007_0000));
    pending_requests.push_back(make_request(MODE_FIT, 32'h0, 32'h0));
    pending_requests.push_back(make_request(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_requests.push_back(make_request(MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_requests.push_back(make_request(MODE_FIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(MODE_PREDICT, 32'h7FFF_FFFF, 32'h0));
    pending_requests.push_back(make_request(MODE_PREDICT, 32'h8000_0000, 32'h0));
    pending_requests.push_back(make_request(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0, 32'h0));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0, 32'h0001_0000));
    pending_requests.push_back(make_request(MODE_ADD, 32'h0, 32'hFFFF_0000));
    pending_requests.push_back(make_request(MODE_FIT, 32'h0, 32'h0));
    wait_drained();

    // Fill the store past full while the receiver holds off.
    pending_requests.push_back(make_request(MODE_CLEAR, 32'h0, 32'h0));
    for (int i = 0; i < STORE_DEPTH + 4; i++)
      pending_requests.push_back(make_request(MODE_ADD, any_value(), any_value()));
    pending_requests.push_back(make_request(MODE_FIT, 32'h0, 32'h0));
    pending_requests.push_back(make_request(MODE_PREDICT, any_value(), 32'h0));
    hold_results = 1'b1;
    repeat (300) @(posedge clk);
    hold_results = 1'b0;
    wait_drained();

    // Random phases across several register settings, extremes included.
    queued = 0;
    for (int phase = 0; queued < RANDOM_ITEMS; phase++) begin
      case (phase % 4)
        0: begin
          write_register(CFG_ORIGIN_X, 32'h0);
          write_register(CFG_ORIGIN_Y, 32'h0);
          write_register(CFG_FIT_INTERCEPT, 32'h1);
        end
        1: begin
          write_register(CFG_ORIGIN_X, 32'h7FFF_FFFF);
          write_register(CFG_ORIGIN_Y, 32'h8000_0000);
          write_register(CFG_FIT_INTERCEPT, 32'h0);
        end
        2: begin
          write_register(CFG_ORIGIN_X, 32'h8000_0000);
          write_register(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
          write_register(CFG_FIT_INTERCEPT, 32'h1);
        end
        default: begin
          write_register(CFG_ORIGIN_X, scaled_value());
          write_register(CFG_ORIGIN_Y, scaled_value());
          write_register(CFG_FIT_INTERCEPT, $urandom_range(0, 1));
        end
      endcase
      for (int s = 0; s < 8; s++) begin
        if ($urandom_range(0, 4) == 0) begin
          // Noise of any mode.
          repeat ($urandom_range(1, 6)) begin
            pending_requests.push_back(make_request(mode_e'($urandom_range(0, 3)),
                                                    any_value(), any_value()));
            queued++;
          end
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(3, 20);
          queue_session(n);
          queued += n + 4;
        end
      end
      wait_drained();
    end

    // Sender pauses while every outstanding result comes back.
    repeat (6)
      pending_requests.push_back(make_request(MODE_PREDICT, $urandom, $urandom));
    while (expected_results.size() == 0) @(posedge clk);
    pause_requests = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    pause_requests = 1'b0;
    wait_drained();

    if (errors == 0) begin
      $display("least_squares_line_fit: match");
    end else begin
      $display("least_squares_line_fit: mismatch");
    end
    $finish;
  end

endmodule
